### design/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and defaults of the connected transport link.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Default depth of the outgoing message queue
  localparam int QUEUE_DEPTH_DEF = 16;

  // Register defaults after reset
  localparam logic [7:0] TIMEOUT_RST = 8'd3;
  localparam logic [2:0] MAXREP_RST  = 3'd3;

  // Register indexes on the configuration port (byte address bit 2)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAXREP  = 1'b1;

  // Input commands
  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_APP   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_OPEN  = 2'd3
  } cmd_t;

  // Received frame types
  typedef enum logic [2:0] {
    FT_DATA       = 3'd0,
    FT_CONNECT    = 3'd1,
    FT_DISCONNECT = 3'd2,
    FT_ACK        = 3'd3,
    FT_NAK        = 3'd4,
    FT_OTHER      = 3'd5
  } ftype_t;

  // Result actions
  typedef enum logic [2:0] {
    ACT_CONNECT    = 3'd0,
    ACT_DISCONNECT = 3'd1,
    ACT_SEND_DATA  = 3'd2,
    ACT_SEND_ACK   = 3'd3,
    ACT_DELIVER    = 3'd4,
    ACT_CLOSED     = 3'd5,
    ACT_OVERFLOW   = 3'd6
  } action_t;

  // Link modes
  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_WAIT   = 2'd2
  } mode_t;

  // One input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  frame_type;
    logic [3:0]  seq_number;
    logic [15:0] message_handle;
    logic [7:0]  first_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  frame_seq;
    logic [15:0] payload_handle;
    logic [7:0]  payload_first_byte;
    logic        last;
  } res_t;

  // Engine to queue control
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [15:0] push_data;
  } q_ctrl_t;

  // Queue status back to the engine
  typedef struct packed {
    logic        empty;
    logic        full;
    logic [15:0] head_data;
  } q_stat_t;

  // Build a result with last cleared
  function automatic res_t mk_res(action_t act, logic [3:0] seq, logic [15:0] handle,
                                  logic [7:0] fb);
    res_t r;
    r.action             = act;
    r.frame_seq          = seq;
    r.payload_handle     = handle;
    r.payload_first_byte = fb;
    r.last               = 1'b0;
    return r;
  endfunction

endpackage

### design/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Outgoing message queue: circular buffer in a memory with a registered,
// write-forwarded read of the next head entry.
// ----------------------------------------------------------------------------
module clt_queue import clt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctrl_t ctrl,
  output q_stat_t stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   rd_r;

  // Advance pointers and count
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (ctrl.pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
    if (ctrl.push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
    end
    count_nxt = count_r + {{(CW-1){1'b0}}, ctrl.push} - {{(CW-1){1'b0}}, ctrl.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write at tail; prefetch the next head entry, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= ctrl.push_data;
    end
    if (ctrl.push && (tail_r == head_nxt)) begin
      rd_r <= ctrl.push_data;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == FULL_CNT);
  assign stat.head_data = rd_r;

endmodule

### design/clt_engine.sv
// ----------------------------------------------------------------------------
// clt_engine
// Link state machine: judges one registered beat against the link state,
// updates the state and produces up to two results.
// ----------------------------------------------------------------------------
module clt_engine import clt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] timeout_ticks,
  input  logic [2:0] max_repeats,
  input  item_t      item,
  input  logic       commit,
  input  q_stat_t    q_stat,
  output q_ctrl_t    q_ctrl,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_n
);

  mode_t       mode_r, mode_nxt;
  logic [3:0]  send_seq_r, send_seq_nxt;
  logic [3:0]  recv_seq_r, recv_seq_nxt;
  logic [2:0]  rep_r, rep_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [7:0]  tcnt_r, tcnt_nxt;
  logic        trun_r, trun_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CLOSED;
      send_seq_r <= '0;
      recv_seq_r <= '0;
      rep_r      <= '0;
      tcnt_r     <= '0;
      trun_r     <= 1'b0;
    end else if (commit) begin
      mode_r     <= mode_nxt;
      send_seq_r <= send_seq_nxt;
      recv_seq_r <= recv_seq_nxt;
      rep_r      <= rep_nxt;
      tcnt_r     <= tcnt_nxt;
      trun_r     <= trun_nxt;
    end
  end

  // Current handle needs no reset
  always_ff @(posedge clk) begin
    if (commit) begin
      cur_r <= cur_nxt;
    end
  end

  // Next state and results
  always_comb begin
    logic        close_en;
    logic        send_en;
    logic [15:0] next_handle;

    mode_nxt     = mode_r;
    send_seq_nxt = send_seq_r;
    recv_seq_nxt = recv_seq_r;
    rep_nxt      = rep_r;
    cur_nxt      = cur_r;
    tcnt_nxt     = tcnt_r;
    trun_nxt     = trun_r;
    res0         = '0;
    res1         = '0;
    res_n        = 2'd0;
    q_ctrl       = '0;
    q_ctrl.push_data = item.message_handle;
    close_en     = 1'b0;
    send_en      = 1'b0;
    next_handle  = '0;

    case (item.command)
      CMD_FRAME: begin
        case (item.frame_type)
          FT_DATA: begin
            if (item.seq_number == recv_seq_r) begin
              // Deliver in order and acknowledge
              res0 = mk_res(ACT_DELIVER, 4'd0, item.message_handle,
                            {6'd0, item.first_byte[1:0]});
              res1 = mk_res(ACT_SEND_ACK, recv_seq_r, 16'd0, 8'd0);
              res_n = 2'd2;
              recv_seq_nxt = recv_seq_r + 4'd1;
            end else if (item.seq_number == (recv_seq_r - 4'd1)) begin
              // Repeated frame: acknowledge again
              res0 = mk_res(ACT_SEND_ACK, item.seq_number, 16'd0, 8'd0);
              res_n = 2'd1;
            end else begin
              close_en = 1'b1;
            end
          end
          FT_CONNECT, FT_DISCONNECT: begin
            close_en = 1'b1;
          end
          FT_ACK: begin
            if ((item.seq_number != send_seq_r) || (mode_r != MODE_WAIT)) begin
              close_en = 1'b1;
            end else begin
              mode_nxt     = MODE_IDLE;
              trun_nxt     = 1'b0;
              send_seq_nxt = send_seq_r + 4'd1;
              send_en      = 1'b1;
            end
          end
          FT_NAK: begin
            if ((item.seq_number != send_seq_r) || (rep_r >= max_repeats) ||
                (mode_r != MODE_WAIT)) begin
              close_en = 1'b1;
            end else begin
              // Resend without restarting the timer
              rep_nxt = rep_r + 3'd1;
              res0    = mk_res(ACT_SEND_DATA, send_seq_r, cur_r, 8'd0);
              res_n   = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_APP: begin
        if (q_stat.full) begin
          res0  = mk_res(ACT_OVERFLOW, 4'd0, 16'd0, 8'd0);
          res_n = 2'd1;
        end else begin
          q_ctrl.push = 1'b1;
        end
        if (mode_r == MODE_IDLE) begin
          send_en = 1'b1;
        end
      end
      CMD_TICK: begin
        if (trun_r) begin
          if (tcnt_r > 8'd1) begin
            tcnt_nxt = tcnt_r - 8'd1;
          end else begin
            tcnt_nxt = '0;
            trun_nxt = 1'b0;
            if ((mode_r == MODE_WAIT) && (rep_r < max_repeats)) begin
              // Timeout: resend and restart the timer
              rep_nxt  = rep_r + 3'd1;
              res0     = mk_res(ACT_SEND_DATA, send_seq_r, cur_r, 8'd0);
              res_n    = 2'd1;
              tcnt_nxt = timeout_ticks;
              trun_nxt = 1'b1;
            end else begin
              close_en = 1'b1;
            end
          end
        end
      end
      CMD_OPEN: begin
        mode_nxt     = MODE_IDLE;
        send_seq_nxt = '0;
        recv_seq_nxt = '0;
        rep_nxt      = '0;
        res0         = mk_res(ACT_CONNECT, 4'd0, 16'd0, 8'd0);
        res_n        = 2'd1;
      end
      default: begin
      end
    endcase

    // Send the next queued message; the link is idle here
    if (send_en) begin
      rep_nxt = '0;
      if (!q_stat.empty || q_ctrl.push) begin
        next_handle = q_stat.empty ? item.message_handle : q_stat.head_data;
        q_ctrl.pop  = 1'b1;
        cur_nxt     = next_handle;
        if (res_n == 2'd0) begin
          res0 = mk_res(ACT_SEND_DATA, send_seq_nxt, next_handle, 8'd0);
        end else begin
          res1 = mk_res(ACT_SEND_DATA, send_seq_nxt, next_handle, 8'd0);
        end
        res_n    = res_n + 2'd1;
        mode_nxt = MODE_WAIT;
        tcnt_nxt = timeout_ticks;
        trun_nxt = 1'b1;
      end
    end

    // Close: disconnect then closed notice
    if (close_en) begin
      mode_nxt = MODE_CLOSED;
      trun_nxt = 1'b0;
      res0     = mk_res(ACT_DISCONNECT, 4'd0, 16'd0, 8'd0);
      res1     = mk_res(ACT_CLOSED, 4'd0, 16'd0, 8'd0);
      res_n    = 2'd2;
    end

    // Mark the last result of this beat
    if (res_n == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1.last = 1'b1;
    end

    // Drop side effects unless the beat commits
    if (!commit) begin
      q_ctrl.push = 1'b0;
      q_ctrl.pop  = 1'b0;
      res_n       = 2'd0;
    end
  end

endmodule

### design/clt_out_fifo.sv
// ----------------------------------------------------------------------------
// clt_out_fifo
// Four-entry result buffer: takes up to two results per cycle, hands out
// one result beat per cycle while it is popped.
// ----------------------------------------------------------------------------
module clt_out_fifo import clt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       res0,
  input  res_t       res1,
  input  logic       pop,
  output res_t       head,
  output logic       not_empty,
  output logic       room2
);

  res_t       buf_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] count_r;

  // Write up to two entries at the write pointer
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      buf_r[wp_r] <= res0;
    end
    if (push_n == 2'd2) begin
      buf_r[wp_r + 2'd1] <= res1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + push_n;
      rp_r    <= rp_r + {1'b0, pop};
      count_r <= count_r + {1'b0, push_n} - {2'b00, pop};
    end
  end

  assign head      = buf_r[rp_r];
  assign not_empty = (count_r != 3'd0);
  assign room2     = (count_r <= 3'd2) || ((count_r == 3'd3) && pop);

endmodule

### design/connected_transport_link.sv
// ----------------------------------------------------------------------------
// connected_transport_link
// Stop-and-wait connected transport link: input register, link engine with
// its outgoing message queue, result buffer and register port.
// ----------------------------------------------------------------------------
// An accepted beat waits in the input register until the result buffer has
// room for two results; its results are registered in the result buffer.
// Throughput: one beat per cycle while results drain; the result port moves
// one result per cycle while out_ready is high.
// Reset: synchronous, active low; clears link state, queue pointers, result
// buffer and registers to defaults. Queue and handle storage are not cleared.
// ----------------------------------------------------------------------------
module connected_transport_link import clt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_frame_type,
  input  logic [3:0]  in_seq_number,
  input  logic [15:0] in_message_handle,
  input  logic [7:0]  in_first_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [3:0]  out_frame_seq,
  output logic [15:0] out_payload_handle,
  output logic [7:0]  out_payload_first_byte,
  output logic        out_last,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_full_r;
  item_t      item_r;
  logic       commit;
  logic [7:0] timeout_r;
  logic [2:0] maxrep_r;
  q_ctrl_t    q_ctrl;
  q_stat_t    q_stat;
  res_t       res0, res1, head;
  logic [1:0] res_n;
  logic       room2;
  logic       pop;

  // Register port: writes complete in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      maxrep_r  <= MAXREP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TIMEOUT: timeout_r <= pwdata[7:0];
        REG_MAXREP:  maxrep_r  <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT: prdata = {24'd0, timeout_r};
      REG_MAXREP:  prdata = {29'd0, maxrep_r};
      default:     prdata = '0;
    endcase
  end

  // Input register: hold a beat until the result buffer has room for two
  assign commit   = in_full_r && room2;
  assign in_ready = !in_full_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command        <= in_command;
      item_r.frame_type     <= in_frame_type;
      item_r.seq_number     <= in_seq_number;
      item_r.message_handle <= in_message_handle;
      item_r.first_byte     <= in_first_byte;
    end
  end

  clt_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .max_repeats   (maxrep_r),
    .item          (item_r),
    .commit        (commit),
    .q_stat        (q_stat),
    .q_ctrl        (q_ctrl),
    .res0          (res0),
    .res1          (res1),
    .res_n         (res_n)
  );

  clt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  // Result buffer and output beat
  assign pop = out_valid && out_ready;

  clt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .res0      (res0),
    .res1      (res1),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_action             = head.action;
  assign out_frame_seq          = head.frame_seq;
  assign out_payload_handle     = head.payload_handle;
  assign out_payload_first_byte = head.payload_first_byte;
  assign out_last               = head.last;

`ifndef NO_ASSERTIONS
  // A stalled input means a beat is waiting in the input register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_full_r)
    else $error("input stalled with empty input register");

  // A committed beat with results shows a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (res_n != 2'd0)) |=> out_valid)
    else $error("committed results not presented");

  // Results of one beat are presented back to back: a non-last result has a follower
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !out_last) |=> out_valid)
    else $error("result pair split");

  // An uncommitted beat stays in the input register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full_r && !commit) |=> in_full_r)
    else $error("input beat lost");
`endif

endmodule

### tb/connected_transport_link_test.sv
// ----------------------------------------------------------------------------
// connected_transport_link_test
// Self-checking bench for the connected transport link. A behavioral copy of
// the link state (modes, sequence numbers, repeat count, timer and message
// queue) predicts every result beat; a monitor compares each beat that leaves
// the result port field by field with the oldest prediction. Directed beats
// cover the frame rules, queue overflow and resends, then random traffic runs
// under several register settings and idle/stall patterns on both ports.
// ----------------------------------------------------------------------------
module connected_transport_link_test;
  import clt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n                  = 1'b0;
  logic        in_valid               = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command             = '0;
  logic [2:0]  in_frame_type          = '0;
  logic [3:0]  in_seq_number          = '0;
  logic [15:0] in_message_handle      = '0;
  logic [7:0]  in_first_byte          = '0;
  logic        out_valid;
  logic        out_ready              = 1'b0;
  logic [2:0]  out_action;
  logic [3:0]  out_frame_seq;
  logic [15:0] out_payload_handle;
  logic [7:0]  out_payload_first_byte;
  logic        out_last;
  logic        psel                   = 1'b0;
  logic        penable                = 1'b0;
  logic        pwrite                 = 1'b0;
  logic [2:0]  paddr                  = '0;
  logic [31:0] pwdata                 = '0;
  logic [31:0] prdata;
  logic        pready;

  connected_transport_link uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (in_command),
    .in_frame_type          (in_frame_type),
    .in_seq_number          (in_seq_number),
    .in_message_handle      (in_message_handle),
    .in_first_byte          (in_first_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_action             (out_action),
    .out_frame_seq          (out_frame_seq),
    .out_payload_handle     (out_payload_handle),
    .out_payload_first_byte (out_payload_first_byte),
    .out_last               (out_last),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  // Mirror of the link state
  logic [7:0]  cfg_timeout  = TIMEOUT_RST;
  logic [2:0]  cfg_max_rep  = MAXREP_RST;
  mode_t       link_mode    = MODE_CLOSED;
  logic [3:0]  tx_seq       = '0;
  logic [3:0]  rx_seq       = '0;
  logic [2:0]  retry_count  = '0;
  logic [15:0] cur_handle   = '0;
  logic [7:0]  ticks_left   = '0;
  bit          timer_on     = 1'b0;
  logic [15:0] msg_queue [QUEUE_DEPTH_DEF];
  int unsigned q_head       = 0;
  int unsigned q_tail       = 0;
  int unsigned q_count      = 0;

  res_t        step_actions[$];
  res_t        actions_due[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          in_held        = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4ms;
    $display("connected_transport_link_test NOT OK");
    $finish;
  end

  // Result port back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Link prediction
  // ---------------------------------------------------------------------------

  // Collect one action of the current beat, two at most
  function automatic void stage(action_t act, logic [3:0] seq, logic [15:0] handle,
                                logic [7:0] fb);
    res_t r;
    if (step_actions.size() < 2) begin
      r.action             = act;
      r.frame_seq          = seq;
      r.payload_handle     = handle;
      r.payload_first_byte = fb;
      r.last               = 1'b0;
      step_actions.push_back(r);
    end
  endfunction

  // Close: stop timer, announce disconnect and closed; the queue stays
  function automatic void drop_link();
    link_mode = MODE_CLOSED;
    timer_on  = 1'b0;
    stage(ACT_DISCONNECT, '0, '0, '0);
    stage(ACT_CLOSED, '0, '0, '0);
  endfunction

  // In idle mode, pop the next queued message and send it
  function automatic void launch_next();
    if (link_mode == MODE_IDLE) begin
      retry_count = '0;
      if (q_count != 0) begin
        cur_handle = msg_queue[q_head];
        q_head     = (q_head + 1) % QUEUE_DEPTH_DEF;
        q_count--;
        stage(ACT_SEND_DATA, tx_seq, cur_handle, '0);
        link_mode  = MODE_WAIT;
        ticks_left = cfg_timeout;
        timer_on   = 1'b1;
      end
    end
  endfunction

  // Apply one accepted beat and queue the results it causes
  function automatic void advance_link(item_t b);
    step_actions.delete();
    case (b.command)
      CMD_FRAME: begin
        case (b.frame_type)
          FT_DATA: begin
            if (b.seq_number == rx_seq) begin
              stage(ACT_DELIVER, '0, b.message_handle, b.first_byte & 8'h03);
              stage(ACT_SEND_ACK, rx_seq, '0, '0);
              rx_seq++;
            end else if (b.seq_number == rx_seq - 4'd1) begin
              stage(ACT_SEND_ACK, b.seq_number, '0, '0);
            end else begin
              drop_link();
            end
          end
          FT_CONNECT, FT_DISCONNECT: begin
            drop_link();
          end
          FT_ACK: begin
            if (b.seq_number != tx_seq || link_mode != MODE_WAIT) begin
              drop_link();
            end else begin
              link_mode = MODE_IDLE;
              timer_on  = 1'b0;
              tx_seq++;
              launch_next();
            end
          end
          FT_NAK: begin
            if (b.seq_number != tx_seq || retry_count >= cfg_max_rep ||
                link_mode != MODE_WAIT) begin
              drop_link();
            end else begin
              retry_count++;
              stage(ACT_SEND_DATA, tx_seq, cur_handle, '0);
            end
          end
          default: begin
          end
        endcase
      end
      CMD_APP: begin
        if (q_count >= QUEUE_DEPTH_DEF) begin
          stage(ACT_OVERFLOW, '0, '0, '0);
        end else begin
          msg_queue[q_tail] = b.message_handle;
          q_tail = (q_tail + 1) % QUEUE_DEPTH_DEF;
          q_count++;
        end
        launch_next();
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (ticks_left > 1) begin
            ticks_left--;
          end else begin
            ticks_left = '0;
            timer_on   = 1'b0;
            // Expiry: resend while repeats remain, else give up
            if (link_mode == MODE_WAIT && retry_count < cfg_max_rep) begin
              retry_count++;
              stage(ACT_SEND_DATA, tx_seq, cur_handle, '0);
              ticks_left = cfg_timeout;
              timer_on   = 1'b1;
            end else begin
              drop_link();
            end
          end
        end
      end
      default: begin
        link_mode   = MODE_IDLE;
        tx_seq      = '0;
        rx_seq      = '0;
        retry_count = '0;
        stage(ACT_CONNECT, '0, '0, '0);
      end
    endcase
    if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
    foreach (step_actions[i]) actions_due.push_back(step_actions[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $realtime, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (actions_due.size() == 0) begin
        $display("%0t unexpected beat: expected none actual action %0d handle %0d",
                 $realtime, out_action, out_payload_handle);
        mismatch_count++;
      end else begin
        want = actions_due.pop_front();
        check_field("action", want.action, out_action);
        check_field("frame_seq", want.frame_seq, out_frame_seq);
        check_field("payload_handle", want.payload_handle, out_payload_handle);
        check_field("payload_first_byte", want.payload_first_byte, out_payload_first_byte);
        check_field("last", want.last, out_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic item_t make_beat(logic [1:0] cmd, logic [2:0] ft, logic [3:0] seq,
                                      logic [15:0] handle, logic [7:0] fb);
    item_t b;
    b.command        = cmd;
    b.frame_type     = ft;
    b.seq_number     = seq;
    b.message_handle = handle;
    b.first_byte     = fb;
    return b;
  endfunction

  // Send one beat after a random gap; valid stays up for a back-to-back beat
  task automatic send_beat(input item_t b);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (in_held) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= b.command;
    in_frame_type     <= b.frame_type;
    in_seq_number     <= b.seq_number;
    in_message_handle <= b.message_handle;
    in_first_byte     <= b.first_byte;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    advance_link(b);
  endtask

  // Drop valid before any pause
  task automatic drop_input();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
      @(posedge clk);
    end
  endtask

  // Let all predicted beats drain, then give the block time to go idle
  task automatic wait_link_quiet();
    drop_input();
    while (actions_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready
  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers, read them back, update the mirror
  task automatic set_link_config(input logic [7:0] timeout, input logic [2:0] max_rep);
    logic [31:0] rd;
    logic [2:0]  addr_timeout;
    logic [2:0]  addr_max_rep;
    addr_timeout = {REG_TIMEOUT, 2'b00};
    addr_max_rep = {REG_MAXREP, 2'b00};
    wait_link_quiet();
    reg_access(1'b1, addr_timeout, {24'd0, timeout}, rd);
    reg_access(1'b1, addr_max_rep, {29'd0, max_rep}, rd);
    cfg_timeout = timeout;
    cfg_max_rep = max_rep;
    reg_access(1'b0, addr_timeout, '0, rd);
    check_field("timeout_ticks readback", {24'd0, timeout}, rd);
    reg_access(1'b0, addr_max_rep, '0, rd);
    check_field("max_repeats readback", {29'd0, max_rep}, rd);
  endtask

  // Mostly well-formed traffic steered by the mirrored state
  function automatic item_t pick_beat();
    item_t       b;
    int unsigned r;
    b = make_beat(CMD_FRAME, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (link_mode == MODE_CLOSED && r < 35) begin
      b.command = CMD_OPEN;
    end else begin
      r = $urandom_range(0, 99);
      // Ack and nak make sense only while waiting; turn most others into messages
      if (r >= 44 && r < 66 && link_mode != MODE_WAIT && $urandom_range(0, 4) != 0) r = 0;
      if (r < 22) begin
        b.command = CMD_APP;
      end else if (r < 44) begin
        b.frame_type = FT_DATA;
        case ($urandom_range(0, 9))
          0:       b.seq_number = 4'($urandom_range(0, 15));
          1, 2:    b.seq_number = rx_seq - 4'd1;
          default: b.seq_number = rx_seq;
        endcase
      end else if (r < 58) begin
        b.frame_type = FT_ACK;
        if ($urandom_range(0, 9) != 0) b.seq_number = tx_seq;
      end else if (r < 66) begin
        b.frame_type = FT_NAK;
        if ($urandom_range(0, 7) != 0) b.seq_number = tx_seq;
      end else if (r < 88) begin
        b.command = CMD_TICK;
      end else if (r < 91) begin
        b.command = CMD_OPEN;
      end else if (r < 94) begin
        b.frame_type = $urandom_range(0, 1) ? FT_CONNECT : FT_DISCONNECT;
      end else begin
        b.frame_type = 3'($urandom_range(5, 7));
      end
    end
    return b;
  endfunction

  // Random traffic of about goal beats
  task automatic run_traffic(input int unsigned goal);
    int unsigned counted;
    item_t       b;
    counted = 0;
    while (counted < goal) begin
      if ($urandom_range(0, 59) == 0) begin
        // Message burst to push the queue past full
        repeat (18) begin
          send_beat(make_beat(CMD_APP, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
          counted++;
        end
      end else begin
        b = pick_beat();
        counted++;
        send_beat(b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frame handling while closed: ignored beats, delivery, re-ack, errors
  task automatic test_frame_rules();
    send_beat(make_beat(CMD_TICK, FT_DATA, 4'h0, 16'h0000, 8'h00));
    send_beat(make_beat(CMD_FRAME, FT_DATA, 4'h0, 16'hffff, 8'hff));
    send_beat(make_beat(CMD_FRAME, FT_DATA, 4'h0, 16'h1234, 8'h00));
    send_beat(make_beat(CMD_FRAME, 3'd7, 4'hf, 16'hffff, 8'hff));
    send_beat(make_beat(CMD_FRAME, FT_DATA, 4'h5, 16'h0000, 8'h80));
    send_beat(make_beat(CMD_FRAME, FT_CONNECT, 4'h0, 16'h0000, 8'h00));
  endtask

  // Fill the queue while closed, overflow, open, then nak, timeout and ack
  task automatic test_queue_and_retries();
    send_beat(make_beat(CMD_APP, FT_DATA, 4'h0, 16'h0000, 8'h00));
    send_beat(make_beat(CMD_APP, FT_DATA, 4'h0, 16'hffff, 8'h00));
    repeat (14) begin
      send_beat(make_beat(CMD_APP, FT_DATA, 4'h0, 16'($urandom_range(0, 65535)), 8'h00));
    end
    send_beat(make_beat(CMD_APP, FT_DATA, 4'h0, 16'haaaa, 8'h00));
    send_beat(make_beat(CMD_OPEN, FT_DATA, 4'h0, 16'h0000, 8'h00));
    send_beat(make_beat(CMD_APP, FT_DATA, 4'h0, 16'h5555, 8'h00));
    send_beat(make_beat(CMD_FRAME, FT_NAK, 4'h0, 16'h0000, 8'h00));
    repeat (3) send_beat(make_beat(CMD_TICK, FT_DATA, 4'h0, 16'h0000, 8'h00));
    send_beat(make_beat(CMD_FRAME, FT_ACK, 4'h0, 16'h0000, 8'h00));
    send_beat(make_beat(CMD_FRAME, FT_ACK, 4'h9, 16'h0000, 8'h00));
  endtask

  task automatic test_no_idling();
    set_link_config(8'd3, 3'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(140);
  endtask

  task automatic test_sender_gaps();
    set_link_config(8'd1, 3'd0);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_traffic(140);
  endtask

  task automatic test_receiver_stalls();
    set_link_config(8'd0, 3'd7);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_traffic(140);
  endtask

  task automatic test_both_idle();
    set_link_config(8'd255, 3'd7);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_traffic(140);
  endtask

  task automatic test_short_timeouts();
    set_link_config(8'($urandom_range(2, 6)), 3'($urandom_range(1, 6)));
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_traffic(140);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_rules();
    test_queue_and_retries();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_short_timeouts();
    wait_link_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("connected_transport_link_test OK");
    end else begin
      $display("connected_transport_link_test NOT OK");
    end
    $finish;
  end

endmodule
